@@ hw/rtl/slope_angle_point_rotation_assert.svh @@
// Assertion macros for the checker file.
`ifndef SLOPE_ANGLE_POINT_ROTATION_ASSERT_SVH
`define SLOPE_ANGLE_POINT_ROTATION_ASSERT_SVH

// Clocked assertion, off while reset is high.
`define SLAP_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("slap assertion failed");

// Clocked assertion that also holds during reset.
`define SLAP_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("slap assertion failed");

`endif

@@ hw/rtl/slap_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package slap_pkg;

  // Defaults for the top level parameters
  localparam int FRAC_BITS_DEF     = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  // Fixed widths
  localparam int COORD_W  = 32;
  localparam int CENTRE_W = 16;
  localparam int GUIDE_W  = 35;
  localparam int CFG_IDX_W = 2;

  // Registers around the micro-rotation stages: input, magnitude, multiply, sum, clip
  localparam int PIPE_EXTRA = 5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Y = 2'd2;

  // Gain correction, unsigned Q30
  localparam int GAIN_W     = 30;
  localparam int LO_BITS    = 16;
  localparam int POST_SHIFT = 14;
  localparam logic [46:0] ROUND_BIAS = 47'd1 << 29;

  // Saturation limits
  localparam logic [COORD_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] SAT_MIN = 32'h8000_0000;

  // Restoring division, for elaboration-time constants only
  function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 64'd0;
    r = 64'd0;
    for (int k = 63; k >= 0; k--) begin
      r = (r << 1) | ((n >> k) & 64'd1);
      if (r >= d) begin
        r = r - d;
        q = q | (64'd1 << k);
      end
    end
    return q;
  endfunction

  // Bitwise integer square root
  function automatic longint unsigned isqrt64(longint unsigned n_in);
    longint unsigned n;
    longint unsigned r;
    longint unsigned b;
    n = n_in;
    r = 64'd0;
    for (int k = 31; k >= 0; k--) begin
      b = 64'd1 << (2 * k);
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  // Inverse CORDIC gain over the given number of stages, Q30
  function automatic logic [GAIN_W-1:0] inv_gain_q30(int stages);
    longint unsigned q;
    longint unsigned d;
    longint unsigned g;
    q = 64'd1 << 60;
    for (int i = 0; i < stages; i++) begin
      d = (64'd1 << (2 * i)) + 64'd1;
      q = q - udiv64(q, d);
    end
    g = isqrt64(q);
    return g[GAIN_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/slap_cordic_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none

module slap_cordic_stage
  import slap_pkg::*;
#(
  parameter int SHIFT = 0,
  parameter int DW    = 36
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic signed [GUIDE_W-1:0] g_in,
  input  logic signed [GUIDE_W-1:0] h_in,
  input  logic signed [DW-1:0]      u_in,
  input  logic signed [DW-1:0]      v_in,
  output logic                      out_valid,
  output logic signed [GUIDE_W-1:0] g_out,
  output logic signed [GUIDE_W-1:0] h_out,
  output logic signed [DW-1:0]      u_out,
  output logic signed [DW-1:0]      v_out
);

  logic                      dir;
  logic signed [GUIDE_W-1:0] gs, hs, g_next, h_next;
  logic signed [DW-1:0]      us, vs, u_next, v_next;

  // Drive the guide toward the x axis and turn the point the same way
  always_comb begin
    dir = ~h_in[GUIDE_W-1];
    gs  = g_in >>> SHIFT;
    hs  = h_in >>> SHIFT;
    us  = u_in >>> SHIFT;
    vs  = v_in >>> SHIFT;
    if (dir) begin
      g_next = g_in + hs;
      h_next = h_in - gs;
      u_next = u_in + vs;
      v_next = v_in - us;
    end else begin
      g_next = g_in - hs;
      h_next = h_in + gs;
      u_next = u_in - vs;
      v_next = v_in + us;
    end
  end

  // Advance the valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  // Hold the vectors of the request in flight
  always_ff @(posedge clk) begin
    if (in_valid) begin
      g_out <= g_next;
      h_out <= h_next;
      u_out <= u_next;
      v_out <= v_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/slap_scale.sv @@
`timescale 1ns / 1ps
`default_nettype none

module slap_scale
  import slap_pkg::*;
#(
  parameter int DW            = 36,
  parameter int FRAC_BITS     = FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic signed [DW-1:0]       u,
  input  logic signed [CENTRE_W-1:0] centre,
  output logic                       out_valid,
  output logic        [COORD_W-1:0]  result,
  output logic                       sat
);

  localparam logic [GAIN_W-1:0] GAIN = inv_gain_q30(CORDIC_STAGES);
  localparam int HW = DW - LO_BITS + GAIN_W;
  localparam int SW = DW + 3;

  logic              valid_a, valid_b, valid_c;
  logic              neg_a, neg_b, neg_c;
  logic [DW-1:0]     mag_next, mag_a;
  logic [HW-1:0]     prod_hi;
  logic [46:0]       prod_lo;
  logic [HW:0]       sum_c;
  logic [DW:0]       mag_c;
  logic signed [SW-1:0] mag_s, r_s, c_s, sum_s;
  logic              overflow;
  logic [COORD_W-1:0] result_next;

  assign mag_next = u[DW-1] ? DW'(-u) : DW'(u);
  assign sum_c    = (HW + 1)'(prod_hi) + (HW + 1)'(prod_lo[46:LO_BITS]);

  // Restore the sign, add the centre back and clip
  always_comb begin
    mag_s    = SW'(signed'({1'b0, mag_c}));
    r_s      = neg_c ? -mag_s : mag_s;
    c_s      = SW'(centre) <<< FRAC_BITS;
    sum_s    = r_s + c_s;
    overflow = ~((&sum_s[SW-1:COORD_W-1]) | ~(|sum_s[SW-1:COORD_W-1]));
    if (overflow) begin
      result_next = sum_s[SW-1] ? SAT_MIN : SAT_MAX;
    end else begin
      result_next = sum_s[COORD_W-1:0];
    end
  end

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      valid_b   <= 1'b0;
      valid_c   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      valid_a   <= in_valid;
      valid_b   <= valid_a;
      valid_c   <= valid_b;
      out_valid <= valid_c;
    end
  end

  // Magnitude, split multiply, rounded sum, final result
  always_ff @(posedge clk) begin
    neg_a   <= u[DW-1];
    mag_a   <= mag_next;
    neg_b   <= neg_a;
    prod_hi <= HW'(mag_a[DW-1:LO_BITS]) * HW'(GAIN);
    prod_lo <= 47'(mag_a[LO_BITS-1:0]) * 47'(GAIN) + ROUND_BIAS;
    neg_c   <= neg_b;
    mag_c   <= sum_c[HW:POST_SHIFT];
    result  <= result_next;
    sat     <= overflow;
  end

endmodule

`default_nettype wire

@@ hw/rtl/slope_angle_point_rotation.sv @@
// Channel   Ports                                 Handshake
// request   point_x, point_y                      start high, busy low
// result    rotated_x, rotated_y, saturated       done strobe, one cycle
// config    cfg_index, cfg_data                   cfg_we, written at once
//
// One point enters per cycle while busy is low; the path holds the input stage,
// one register per micro-rotation and four in the gain scaling.
// The multiply pair of the gain scaling sets the clock.
// Reset is synchronous; busy is high during reset and in the cycle after it.
// The receiver cannot stall: each result shows for one cycle only.
`timescale 1ns / 1ps
`default_nettype none

module slope_angle_point_rotation
  import slap_pkg::*;
#(
  parameter int FRAC_BITS     = FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [COORD_W-1:0]  point_x,
  input  logic signed [COORD_W-1:0]  point_y,
  output logic                       done,
  output logic signed [COORD_W-1:0]  rotated_x,
  output logic signed [COORD_W-1:0]  rotated_y,
  output logic                       saturated,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [COORD_W-1:0]         cfg_data
);

  localparam int DW = ((COORD_W > CENTRE_W + FRAC_BITS) ? COORD_W
                                                         : CENTRE_W + FRAC_BITS) + 4;
  localparam logic signed [GUIDE_W-1:0] ONE_G = GUIDE_W'(1) << FRAC_BITS;

  logic signed [COORD_W-1:0]  slope;
  logic signed [CENTRE_W-1:0] centre_x;
  logic signed [CENTRE_W-1:0] centre_y;

  logic                      accept;
  logic signed [DW-1:0]      cx_sc, cy_sc;
  logic                      stage_valid [CORDIC_STAGES+1];
  logic signed [GUIDE_W-1:0] stage_g [CORDIC_STAGES+1];
  logic signed [GUIDE_W-1:0] stage_h [CORDIC_STAGES+1];
  logic signed [DW-1:0]      stage_u [CORDIC_STAGES+1];
  logic signed [DW-1:0]      stage_v [CORDIC_STAGES+1];
  logic                      valid_y, sat_x, sat_y;
  logic [COORD_W-1:0]        res_x, res_y;

  assign accept = start & ~busy;
  assign cx_sc  = DW'(centre_x) <<< FRAC_BITS;
  assign cy_sc  = DW'(centre_y) <<< FRAC_BITS;

  // Hold busy through reset and the cycle after it
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // Configuration writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      slope    <= '0;
      centre_x <= '0;
      centre_y <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SLOPE:    slope    <= cfg_data;
        REG_CENTRE_X: centre_x <= cfg_data[CENTRE_W-1:0];
        REG_CENTRE_Y: centre_y <= cfg_data[CENTRE_W-1:0];
        default: ;
      endcase
    end
  end

  // Input stage: offset from the centre and turn a quarter
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid[0] <= 1'b0;
    end else begin
      stage_valid[0] <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_u[0] <= cy_sc - DW'(point_y);
      stage_v[0] <= DW'(point_x) - cx_sc;
      stage_h[0] <= GUIDE_W'(slope);
    end
  end

  assign stage_g[0] = ONE_G;

  // Micro-rotation stages
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    slap_cordic_stage #(
      .SHIFT (i),
      .DW    (DW)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[i]),
      .g_in      (stage_g[i]),
      .h_in      (stage_h[i]),
      .u_in      (stage_u[i]),
      .v_in      (stage_v[i]),
      .out_valid (stage_valid[i+1]),
      .g_out     (stage_g[i+1]),
      .h_out     (stage_h[i+1]),
      .u_out     (stage_u[i+1]),
      .v_out     (stage_v[i+1])
    );
  end

  // Gain removal and clipping, one unit per coordinate
  slap_scale #(
    .DW            (DW),
    .FRAC_BITS     (FRAC_BITS),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_scale_x (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stage_valid[CORDIC_STAGES]),
    .u         (stage_u[CORDIC_STAGES]),
    .centre    (centre_x),
    .out_valid (done),
    .result    (res_x),
    .sat       (sat_x)
  );

  slap_scale #(
    .DW            (DW),
    .FRAC_BITS     (FRAC_BITS),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_scale_y (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stage_valid[CORDIC_STAGES] & ~stage_g[CORDIC_STAGES][GUIDE_W-1]
                | stage_valid[CORDIC_STAGES]),
    .u         (stage_v[CORDIC_STAGES]),
    .centre    (centre_y),
    .out_valid (valid_y),
    .result    (res_y),
    .sat       (sat_y)
  );

  // Present the result
  assign rotated_x = res_x;
  assign rotated_y = res_y;
  assign saturated = done & valid_y & (sat_x | sat_y);

endmodule

`default_nettype wire

@@ hw/rtl/slap_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "slope_angle_point_rotation_assert.svh"

module slap_checker
  import slap_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic                      done,
  input logic signed [COORD_W-1:0] rotated_x,
  input logic signed [COORD_W-1:0] rotated_y,
  input logic                      saturated
);

  localparam int LATENCY = CORDIC_STAGES + PIPE_EXTRA;

  // Reset flushes results and blocks requests
  `SLAP_ASSERT_RST(a_flush_on_reset, clk, rst |=> !done && busy)

  // Every result traces back to a request a fixed latency earlier
  `SLAP_ASSERT(a_result_latency, clk, rst, done |-> $past(start && !busy, LATENCY))

  // The flag only rides on a result
  `SLAP_ASSERT(a_flag_with_result, clk, rst, saturated |-> done)

  // A clipped result carries a limit value
  `SLAP_ASSERT(a_flag_value, clk, rst,
    saturated |-> rotated_x == SAT_MAX || rotated_x == SAT_MIN ||
                  rotated_y == SAT_MAX || rotated_y == SAT_MIN)

endmodule

bind slope_angle_point_rotation slap_checker #(
  .CORDIC_STAGES (CORDIC_STAGES)
) u_slap_checker (.*);

`default_nettype wire
